// ===== hw/rtl/pvm_pkg.sv =====
package pvm_pkg;

    // Request codes on the action field
    localparam logic [3:0] ACT_TICK   = 4'd0;
    localparam logic [3:0] ACT_WRITE  = 4'd1;
    localparam logic [3:0] ACT_SET    = 4'd2;
    localparam logic [3:0] ACT_VOLPAN = 4'd3;
    localparam logic [3:0] ACT_PAN    = 4'd4;
    localparam logic [3:0] ACT_VOL    = 4'd5;
    localparam logic [3:0] ACT_PLAY   = 4'd6;
    localparam logic [3:0] ACT_STOP   = 4'd7;
    localparam logic [3:0] ACT_LOOP   = 4'd8;

    localparam logic [17:0] MIX_RATE_RESET = 18'd48000;

    // Rounding: half of 127 * 65536, and the reciprocal of 127 scaled by 2^30
    localparam logic [39:0] ROUND_HALF = 40'd4161536;
    localparam logic [23:0] RECIP_127  = 24'd8454661;
    localparam int          RECIP_SHIFT = 30;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 18;

    typedef struct packed {
        logic [15:0]        base;
        logic [15:0]        length;
        logic [15:0]        loop_begin;
        logic [15:0]        pos;
        logic [15:0]        frac;
        logic [23:0]        step;
        logic [15:0]        gain;
        logic signed [15:0] pan;
        logic               looping;
    } voice_rec_t;

endpackage

// ===== hw/rtl/pvm_divider.sv =====
module pvm_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pvm_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [pvm_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [pvm_pkg::DIVIDEND_W-1:0]   quotient,
    output logic [pvm_pkg::DIVISOR_W-1:0]    remainder
);
    import pvm_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [4:0]            cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/pvm_sample_ram.sv =====
module pvm_sample_ram #(
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [2**ADDR_W];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pcm_voice_mixer.sv =====
// From accept to m_valid: write sample goes straight to ST_OUT; volume, pan, play,
// stop, loop points pass ST_VRD, ST_VMOD, ST_VWR; set voice data adds ST_DIV on the
// shared 32-step divider. Tick: ST_TRD per voice, ST_TSRD to ST_TWR per playing one,
// ST_TMOD on a loop wrap. One request at a time; the next is taken from the cycle
// after the result loads, while it waits in m_*. Reset (synchronous, aresetn low)
// stops all voices, empties voice records, sets mix_rate to 48000; samples stay.
module pcm_voice_mixer #(
    parameter int VOICES           = 8,
    parameter int SAMPLE_ADDR_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [17:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_action,
    input  logic [2:0]         s_voice,
    input  logic [15:0]        s_address,
    input  logic [7:0]         s_sample_byte,
    input  logic [15:0]        s_length,
    input  logic [15:0]        s_loop_begin,
    input  logic [15:0]        s_sample_rate,
    input  logic [15:0]        s_volume,
    input  logic signed [15:0] s_pan_cos,
    input  logic               s_loop_flag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left,
    output logic signed [15:0] m_right,
    output logic [7:0]         m_playing_mask,
    output logic [3:0]         m_free_voice
);
    import pvm_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VIDX_W-1:0] VLAST = VIDX_W'(VOICES - 1);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_VRD   = 14'b00000000000010,
        ST_VMOD  = 14'b00000000000100,
        ST_DIV   = 14'b00000000001000,
        ST_VWR   = 14'b00000000010000,
        ST_TRD   = 14'b00000000100000,
        ST_TSRD  = 14'b00000001000000,
        ST_TMUL1 = 14'b00000010000000,
        ST_TMUL2 = 14'b00000100000000,
        ST_TQ    = 14'b00001000000000,
        ST_TACC  = 14'b00010000000000,
        ST_TMOD  = 14'b00100000000000,
        ST_TWR   = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [3:0]         act_reg;
    logic [VIDX_W-1:0]  vsel_reg;
    logic [15:0]        address_reg;
    logic [15:0]        length_reg;
    logic [15:0]        lstart_reg;
    logic [15:0]        rate_reg;
    logic [15:0]        volume_reg;
    logic signed [15:0] pan_reg;
    logic               loop_reg;

    logic [17:0]        mix_rate_reg;
    logic [VOICES-1:0]  playing_reg;
    logic [VOICES-1:0]  vvalid_reg;
    logic [VIDX_W-1:0]  vidx_reg;

    // voice record memory: one write port, one registered read port
    voice_rec_t         vmem [VOICES];
    voice_rec_t         vrd_reg;
    logic               vrd_valid_reg;
    voice_rec_t         rec;
    voice_rec_t         vmod_rec;
    voice_rec_t         wrec_reg;
    logic               vmem_we;
    logic [VIDX_W-1:0]  vmem_addr;

    // tick datapath
    logic [16:0]        adv_pos_reg;
    logic [15:0]        adv_frac_reg;
    logic               neg_reg;
    logic [22:0]        mag1_reg;
    logic [39:0]        magl_reg;
    logic [39:0]        magr_reg;
    logic [15:0]        ql_reg;
    logic [15:0]        qr_reg;
    logic signed [23:0] accl_reg;
    logic signed [23:0] accr_reg;

    logic               accept;
    logic [5:0]         voice_ext;
    logic [VIDX_W-1:0]  s_vsel;
    logic               s_vok;

    logic                  ram_we;
    logic [23:0]           ram_wext;
    logic [23:0]           ram_rsum;
    logic [7:0]            ram_rdata;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVISOR_W-1:0]  div_rem;

    logic [24:0]        frac_sum;
    logic [6:0]         smag;
    logic [15:0]        pan_l;
    logic [16:0]        pan_r;
    logic [23:0]        xl;
    logic [23:0]        xr;
    logic [47:0]        ql_full;
    logic [47:0]        qr_full;
    logic               wrap_hit;

    logic               m_valid_reg;
    logic signed [15:0] m_left_reg;
    logic signed [15:0] m_right_reg;
    logic [7:0]         m_mask_reg;
    logic [3:0]         m_free_reg;
    logic [7:0]         mask_val;
    logic [3:0]         free_val;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign voice_ext = {3'b000, s_voice};
    assign s_vsel    = voice_ext[VIDX_W-1:0];
    assign s_vok     = int'(s_voice) < VOICES;

    assign vmem_addr = (act_reg == ACT_TICK) ? vidx_reg : vsel_reg;
    assign rec       = vrd_valid_reg ? vrd_reg : '0;

    // sample memory: write address from the request, read at base + position
    assign ram_wext = {8'd0, s_address};
    assign ram_rsum = {8'd0, rec.base} + {8'd0, rec.pos};

    pvm_sample_ram #(
        .ADDR_W (SAMPLE_ADDR_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wext[SAMPLE_ADDR_BITS-1:0]),
        .wdata (s_sample_byte),
        .raddr (ram_rsum[SAMPLE_ADDR_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // shared divider: voice step at set-up, loop wrap modulo at tick
    pvm_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // advance by the 8.16 step
    assign frac_sum = {9'd0, rec.frac} + {1'b0, rec.step};

    // centre the byte and clamp to +127; keep sign and magnitude apart
    always_comb begin
        if (ram_rdata < 8'd127) begin
            smag = 7'(8'd127 - ram_rdata);
        end else if (ram_rdata >= 8'd254) begin
            smag = 7'd127;
        end else begin
            smag = 7'(ram_rdata - 8'd127);
        end
    end

    // (1 + pan) in Q1.15 and (1 - pan) in Q2.15, both non-negative
    assign pan_l = {~wrec_reg.pan[15], wrec_reg.pan[14:0]};
    assign pan_r = 17'd32768 - {wrec_reg.pan[15], wrec_reg.pan};

    // round half up on the magnitude, then divide by 127 * 65536
    assign xl      = 24'((magl_reg + ROUND_HALF) >> 16);
    assign xr      = 24'((magr_reg + ROUND_HALF) >> 16);
    assign ql_full = xl * RECIP_127;
    assign qr_full = xr * RECIP_127;

    assign wrap_hit = adv_pos_reg >= {1'b0, wrec_reg.length};

    // record as modified by a voice request
    always_comb begin
        vmod_rec = rec;
        case (act_reg)
            ACT_SET: begin
                vmod_rec.base       = address_reg;
                vmod_rec.length     = length_reg;
                vmod_rec.pos        = '0;
                vmod_rec.frac       = '0;
                vmod_rec.looping    = 1'b0;
                vmod_rec.loop_begin = '0;
            end
            ACT_VOLPAN: begin
                vmod_rec.gain = volume_reg;
                vmod_rec.pan  = pan_reg;
            end
            ACT_PAN: begin
                vmod_rec.pan = pan_reg;
            end
            ACT_VOL: begin
                vmod_rec.gain = volume_reg;
            end
            ACT_PLAY: begin
                vmod_rec.pos     = '0;
                vmod_rec.frac    = '0;
                vmod_rec.looping = loop_reg;
            end
            ACT_LOOP: begin
                if (lstart_reg != 16'd0) begin
                    vmod_rec.loop_begin = lstart_reg;
                end
                if (length_reg != 16'd0) begin
                    vmod_rec.length = length_reg;
                end
            end
            default: ;
        endcase
    end

    // control
    always_comb begin
        state_next   = state_reg;
        vmem_we      = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_TICK: begin
                            state_next = ST_TRD;
                        end
                        ACT_WRITE: begin
                            ram_we     = 1'b1;
                            state_next = ST_OUT;
                        end
                        ACT_SET, ACT_VOLPAN, ACT_PAN, ACT_VOL, ACT_PLAY, ACT_STOP,
                        ACT_LOOP: begin
                            state_next = s_vok ? ST_VRD : ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_VRD: begin
                state_next = ST_VMOD;
            end
            ST_VMOD: begin
                if (act_reg == ACT_SET) begin
                    div_start    = 1'b1;
                    div_dividend = {rate_reg, 16'd0};
                    div_divisor  = mix_rate_reg;
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_VWR;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_VWR;
                end
            end
            ST_VWR: begin
                vmem_we    = 1'b1;
                state_next = ST_OUT;
            end
            ST_TRD: begin
                if (playing_reg[vidx_reg]) begin
                    state_next = ST_TSRD;
                end else if (vidx_reg == VLAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_TSRD: begin
                state_next = ST_TMUL1;
            end
            ST_TMUL1: begin
                state_next = ST_TMUL2;
            end
            ST_TMUL2: begin
                state_next = ST_TQ;
            end
            ST_TQ: begin
                state_next = ST_TACC;
            end
            ST_TACC: begin
                if (wrap_hit && wrec_reg.looping && (wrec_reg.length != 16'd0)) begin
                    div_start    = 1'b1;
                    div_dividend = {15'd0, adv_pos_reg};
                    div_divisor  = {2'b00, wrec_reg.length};
                    state_next   = ST_TMOD;
                end else begin
                    state_next = ST_TWR;
                end
            end
            ST_TMOD: begin
                if (div_done) begin
                    state_next = ST_TWR;
                end
            end
            ST_TWR: begin
                vmem_we    = 1'b1;
                state_next = (vidx_reg == VLAST) ? ST_OUT : ST_TRD;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // voice memory ports
    always_ff @(posedge aclk) begin
        if (vmem_we) begin
            vmem[vmem_addr] <= wrec_reg;
        end
        vrd_reg <= vmem[vmem_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mix_rate_reg  <= MIX_RATE_RESET;
            playing_reg   <= '0;
            vvalid_reg    <= '0;
            vrd_valid_reg <= 1'b0;
            vidx_reg      <= '0;
            act_reg       <= ACT_TICK;
            vsel_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vrd_valid_reg <= vvalid_reg[vmem_addr];
            if (cfg_wr_en) begin
                mix_rate_reg <= cfg_wr_data;
            end
            if (accept) begin
                act_reg  <= s_action;
                vsel_reg <= s_vsel;
                vidx_reg <= '0;
            end
            if (vmem_we) begin
                vvalid_reg[vmem_addr] <= 1'b1;
            end
            if (state_reg == ST_VWR) begin
                case (act_reg)
                    ACT_SET, ACT_STOP: playing_reg[vsel_reg] <= 1'b0;
                    ACT_PLAY:          playing_reg[vsel_reg] <= 1'b1;
                    default:           ;
                endcase
            end
            // drop a voice that runs off its end without a loop
            if (state_reg == ST_TACC && wrap_hit &&
                !(wrec_reg.looping && (wrec_reg.length != 16'd0))) begin
                playing_reg[vidx_reg] <= 1'b0;
            end
            if ((state_reg == ST_TRD && !playing_reg[vidx_reg]) || state_reg == ST_TWR) begin
                if (vidx_reg != VLAST) begin
                    vidx_reg <= vidx_reg + 1'b1;
                end
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            address_reg <= s_address;
            length_reg  <= s_length;
            lstart_reg  <= s_loop_begin;
            rate_reg    <= s_sample_rate;
            volume_reg  <= s_volume;
            pan_reg     <= s_pan_cos;
            loop_reg    <= s_loop_flag;
            accl_reg    <= '0;
            accr_reg    <= '0;
        end
        case (state_reg)
            ST_VMOD: begin
                wrec_reg <= vmod_rec;
            end
            ST_DIV: begin
                // saturate the step to 24 bits; a zero mix rate gives no step
                if (div_done) begin
                    if (mix_rate_reg == 18'd0) begin
                        wrec_reg.step <= '0;
                    end else if (div_quo[31:24] != 8'd0) begin
                        wrec_reg.step <= 24'hffffff;
                    end else begin
                        wrec_reg.step <= div_quo[23:0];
                    end
                end
            end
            ST_TSRD: begin
                wrec_reg     <= rec;
                adv_pos_reg  <= {1'b0, rec.pos} + {8'd0, frac_sum[24:16]};
                adv_frac_reg <= frac_sum[15:0];
            end
            ST_TMUL1: begin
                neg_reg  <= ram_rdata < 8'd127;
                mag1_reg <= smag * wrec_reg.gain;
            end
            ST_TMUL2: begin
                magl_reg <= 40'(mag1_reg * pan_l);
                magr_reg <= 40'(mag1_reg * pan_r);
            end
            ST_TQ: begin
                ql_reg <= ql_full[RECIP_SHIFT+15:RECIP_SHIFT];
                qr_reg <= qr_full[RECIP_SHIFT+15:RECIP_SHIFT];
            end
            ST_TACC: begin
                accl_reg <= neg_reg ? accl_reg - 24'(ql_reg) : accl_reg + 24'(ql_reg);
                accr_reg <= neg_reg ? accr_reg - 24'(qr_reg) : accr_reg + 24'(qr_reg);
                if (!wrap_hit) begin
                    wrec_reg.pos  <= adv_pos_reg[15:0];
                    wrec_reg.frac <= adv_frac_reg;
                end else if (wrec_reg.looping && (wrec_reg.length != 16'd0)) begin
                    wrec_reg.frac <= adv_frac_reg;
                end else begin
                    wrec_reg.pos  <= '0;
                    wrec_reg.frac <= '0;
                end
            end
            ST_TMOD: begin
                if (div_done) begin
                    wrec_reg.pos <= div_rem[15:0] + wrec_reg.loop_begin;
                end
            end
            default: ;
        endcase
    end

    // status after the request: playing mask and lowest free voice
    always_comb begin
        mask_val = '0;
        free_val = 4'(VOICES > 15 ? 15 : VOICES);
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (i < 8) begin
                mask_val[i % 8] = playing_reg[i];
            end
            if (!playing_reg[i]) begin
                free_val = 4'(i > 15 ? 15 : i);
            end
        end
    end

    // result register; hold until taken
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            if (act_reg == ACT_TICK) begin
                if (accl_reg > 24'sd32767) begin
                    m_left_reg <= 16'sh7fff;
                end else if (accl_reg < -24'sd32768) begin
                    m_left_reg <= -16'sh8000;
                end else begin
                    m_left_reg <= accl_reg[15:0];
                end
                if (accr_reg > 24'sd32767) begin
                    m_right_reg <= 16'sh7fff;
                end else if (accr_reg < -24'sd32768) begin
                    m_right_reg <= -16'sh8000;
                end else begin
                    m_right_reg <= accr_reg[15:0];
                end
            end else begin
                m_left_reg  <= '0;
                m_right_reg <= '0;
            end
            m_mask_reg <= mask_val;
            m_free_reg <= free_val;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left         = m_left_reg;
    assign m_right        = m_right_reg;
    assign m_playing_mask = m_mask_reg;
    assign m_free_voice   = m_free_reg;

endmodule
